>>> hw/rtl/tes_pkg.sv
package tes_pkg;

  // Encoding codes reported with the final byte of a data set.
  typedef enum logic [2:0] {
    ENC_UTF8     = 3'd0,
    ENC_UTF8_BOM = 3'd1,
    ENC_UTF16_LE = 3'd2,
    ENC_UTF16_BE = 3'd3,
    ENC_ANSI     = 3'd4
  } enc_code_t;

  // One input word as it travels from the input register to the sniffer core.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } tes_item_t;

  // Byte order marks.
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;
  localparam logic [7:0] BOM16_FF = 8'hFF;
  localparam logic [7:0] BOM16_FE = 8'hFE;

  // UTF-8 lead and continuation byte classes.
  localparam logic [7:0] MASK_2LEAD = 8'hE0;
  localparam logic [7:0] PAT_2LEAD  = 8'hC0;
  localparam logic [7:0] MASK_3LEAD = 8'hF0;
  localparam logic [7:0] PAT_3LEAD  = 8'hE0;
  localparam logic [7:0] MASK_4LEAD = 8'hF8;
  localparam logic [7:0] PAT_4LEAD  = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  // Bytes-seen counter saturates at this value.
  localparam logic [1:0] SEEN_MAX = 2'd3;

endpackage

>>> hw/rtl/tes_in_stage.sv
module tes_in_stage
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  logic       slot_free,
  output logic       item_vld,
  output logic       step,
  output tes_item_t  item
);

  logic      vld_r;
  logic      vld_nxt;
  tes_item_t item_r;
  logic      accept;

  // A word leaves the register unless it is final and the result slot is busy.
  assign step     = vld_r && (!item_r.final_byte || slot_free);
  assign in_stall = vld_r && !step;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (step) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte  <= in_data_byte;
      item_r.final_byte <= in_final_byte;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> hw/rtl/tes_core.sv
module tes_core
  import tes_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  tes_item_t item,
  output enc_code_t code
);

  logic [1:0] seen_r,   seen_nxt;
  logic [7:0] first_r,  first_nxt;
  logic [7:0] second_r, second_nxt;
  logic       bom_r,    bom_nxt;
  logic [1:0] pend_r,   pend_nxt;
  logic       ok_r,     ok_nxt;
  logic [7:0] b;

  assign b = item.data_byte;

  // Capture the leading bytes and test for the UTF-8 byte order mark.
  always_comb begin
    first_nxt  = first_r;
    second_nxt = second_r;
    bom_nxt    = bom_r;
    case (seen_r)
      2'd0: first_nxt = b;
      2'd1: second_nxt = b;
      2'd2: bom_nxt = (first_r == BOM8_B0) && (second_r == BOM8_B1) && (b == BOM8_B2);
      default: ;
    endcase
    seen_nxt = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + 2'd1;
  end

  // Loose UTF-8 check; once failed, later bytes are not examined.
  always_comb begin
    pend_nxt = pend_r;
    ok_nxt   = ok_r;
    if (ok_r) begin
      if (pend_r != 2'd0) begin
        if ((b & MASK_CONT) != PAT_CONT) begin
          ok_nxt = 1'b0;
        end else begin
          pend_nxt = pend_r - 2'd1;
        end
      end else if (b[7]) begin
        if ((b & MASK_2LEAD) == PAT_2LEAD) begin
          pend_nxt = 2'd1;
        end else if ((b & MASK_3LEAD) == PAT_3LEAD) begin
          pend_nxt = 2'd2;
        end else if ((b & MASK_4LEAD) == PAT_4LEAD) begin
          pend_nxt = 2'd3;
        end else begin
          ok_nxt = 1'b0;
        end
      end
    end
  end

  // Classification uses the state as updated by the current word.
  always_comb begin
    if (seen_nxt == SEEN_MAX && bom_nxt) begin
      code = ENC_UTF8_BOM;
    end else if (seen_nxt >= 2'd2 && first_nxt == BOM16_FF && second_nxt == BOM16_FE) begin
      code = ENC_UTF16_LE;
    end else if (seen_nxt >= 2'd2 && first_nxt == BOM16_FE && second_nxt == BOM16_FF) begin
      code = ENC_UTF16_BE;
    end else if (ok_nxt) begin
      code = ENC_UTF8;
    end else begin
      code = ENC_ANSI;
    end
  end

  // State clears after each final word.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.final_byte)) begin
      seen_r   <= 2'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
      bom_r    <= 1'b0;
      pend_r   <= 2'd0;
      ok_r     <= 1'b1;
    end else if (step) begin
      seen_r   <= seen_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      bom_r    <= bom_nxt;
      pend_r   <= pend_nxt;
      ok_r     <= ok_nxt;
    end
  end

endmodule

>>> hw/rtl/tes_out_stage.sv
module tes_out_stage
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  enc_code_t  code,
  output logic       slot_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_encoding_code
);

  logic      vld_r;
  logic      vld_nxt;
  enc_code_t code_r;

  // The slot can take a new result when empty or being drained this cycle.
  assign slot_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= code;
    end
  end

  assign out_valid         = vld_r;
  assign out_encoding_code = code_r;

endmodule

>>> hw/rtl/text_encoding_sniffer_unit.sv
// Channel | Direction | Ports                               | Handshake
// in_     | input     | in_data_byte[7:0], in_final_byte    | in_valid / in_stall
// out_    | output    | out_encoding_code[2:0]              | out_valid / out_stall
//
// One word is accepted per cycle while in_stall is low; a final word's result is registered in the output register.
// The limit is the input register feeding the combinational sniffer logic.
// Synchronous active-low reset empties both registers and clears the sniffer state.
// A stalled result holds the output register; the input register keeps taking
// non-final words, and stalls only while a final word waits for the result slot.
module text_encoding_sniffer_unit
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_encoding_code
);

  tes_item_t item;
  logic      item_vld;
  logic      step;
  logic      slot_free;
  enc_code_t code;

  tes_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .slot_free    (slot_free),
    .item_vld     (item_vld),
    .step         (step),
    .item         (item)
  );

  tes_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item),
    .code (code)
  );

  tes_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step && item.final_byte),
    .code             (code),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_encoding_code(out_encoding_code)
  );

  // The input side only stalls while it holds a word.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_vld)
    else $error("input stalled with an empty input register");

  // A final word never overwrites a result that is still waiting.
  a_final_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.final_byte) |-> slot_free)
    else $error("final word advanced into an occupied result slot");

  // Every final word yields a result in the next cycle.
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.final_byte) |=> out_valid)
    else $error("final word produced no result");

endmodule
